@@ rtl/core/waveform_charge_integrator_core_defines.svh @@
// assertion macros shared by the charge integrator rtl
// needs clk_i and rst_ni in the module that uses them

`ifndef WAVEFORM_CHARGE_INTEGRATOR_CORE_DEFINES_SVH
`define WAVEFORM_CHARGE_INTEGRATOR_CORE_DEFINES_SVH

// checked only outside reset
`define WCI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define WCI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/wci_pkg.sv @@
// shared types and constants of the charge integrator core
// no dependencies

package wci_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 13;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SUM_W      = SAMPLE_W + IDX_W;
  localparam int PROD_W     = LEN_W + SAMPLE_W;
  localparam int DIFF_W     = PROD_W + 2;
  localparam int BASE_W     = 17;
  localparam int CHG_W      = 29;
  localparam int ITER_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_LEN     = 3'd0,
    CFG_BASELINE_LEN = 3'd1,
    CFG_SHORT_LEN    = 3'd2,
    CFG_LONG_LEN     = 3'd3,
    CFG_REVERSE      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic acc_en;    // accept one sample into the accumulators
    logic take;      // snapshot sums and load the divider
    logic div_step;  // one restoring division step
    logic scale;     // latch baseline and gate products
    logic load;      // write the result word to the output register
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic emit;      // current point closes the gates
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/wci_ctrl.sv @@
// controller of the charge integrator: sequences sample intake, division and output
// depends on wci_pkg and waveform_charge_integrator_core_defines.svh

`include "waveform_charge_integrator_core_defines.svh"

module wci_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wci_pkg::sts_t sts_i,
  output wci_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  localparam logic [wci_pkg::ITER_W-1:0] LastIter = wci_pkg::ITER_W'(wci_pkg::SUM_W - 1);

  wci_pkg::state_e             state_q, state_d;
  logic [wci_pkg::ITER_W-1:0]  iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wci_pkg::ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    unique case (state_q)
      wci_pkg::ST_IDLE: begin
        iter_d = '0;
        if (sts_i.in_valid && sts_i.emit) begin
          state_d = wci_pkg::ST_DIVIDE;
        end
      end
      wci_pkg::ST_DIVIDE: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          state_d = wci_pkg::ST_SCALE;
        end
      end
      wci_pkg::ST_SCALE: begin
        state_d = wci_pkg::ST_WRITE;
      end
      wci_pkg::ST_WRITE: begin
        if (sts_i.out_free) begin
          state_d = wci_pkg::ST_IDLE;
        end
      end
      default: state_d = wci_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      wci_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.acc_en = sts_i.in_valid;
        cmd_o.take   = sts_i.in_valid && sts_i.emit;
      end
      wci_pkg::ST_DIVIDE: cmd_o.div_step = 1'b1;
      wci_pkg::ST_SCALE:  cmd_o.scale    = 1'b1;
      wci_pkg::ST_WRITE:  cmd_o.load     = sts_i.out_free;
      default: ;
    endcase
  end

  `WCI_ASSERT(a_load_free, cmd_o.load |-> sts_i.out_free, "result written over a waiting word")
  `WCI_ASSERT(a_take_starts_div,
      cmd_o.take |=> (state_q == wci_pkg::ST_DIVIDE) && (iter_q == '0),
      "division did not start after the closing point")
  `WCI_ASSERT(a_iter_bound, (state_q == wci_pkg::ST_DIVIDE) |-> (iter_q <= LastIter),
      "division step count overran")

endmodule

@@ rtl/core/wci_accum.sv @@
// record position tracking and baseline / gate accumulators
// depends on wci_pkg

module wci_accum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wci_pkg::cmd_t                 cmd_i,
  input  logic [wci_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [wci_pkg::LEN_W-1:0]     wave_len_i,
  input  logic [wci_pkg::LEN_W-1:0]     baseline_len_i,
  input  logic [wci_pkg::LEN_W-1:0]     short_len_i,
  input  logic [wci_pkg::LEN_W-1:0]     long_len_i,
  output logic                          emit_o,
  output logic [wci_pkg::SUM_W-1:0]     base_sum_o,
  output logic [wci_pkg::CNT_W-1:0]     base_count_o,
  output logic [wci_pkg::SUM_W-1:0]     short_sum_o,
  output logic [wci_pkg::SUM_W-1:0]     long_sum_o
);

  localparam logic [wci_pkg::LEN_W-1:0] MaxLen = wci_pkg::LEN_W'(wci_pkg::MAX_POINTS);

  logic [wci_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                      done_q, done_d;
  logic [wci_pkg::SUM_W-1:0] base_sum_q, base_sum_d;
  logic [wci_pkg::CNT_W-1:0] base_cnt_q, base_cnt_d;
  logic [wci_pkg::SUM_W-1:0] short_sum_q, short_sum_d;
  logic [wci_pkg::SUM_W-1:0] long_sum_q, long_sum_d;

  logic [wci_pkg::LEN_W-1:0] len;
  logic [wci_pkg::LEN_W:0]   s_end, l_end;
  logic [wci_pkg::LEN_W:0]   pos;
  logic                      in_base, in_short, in_long, last;
  logic [wci_pkg::SUM_W-1:0] smp;

  always_comb begin
    if (wave_len_i == '0) begin
      len = wci_pkg::LEN_W'(1);
    end else if (wave_len_i > MaxLen) begin
      len = MaxLen;
    end else begin
      len = wave_len_i;
    end
    pos      = (wci_pkg::LEN_W + 1)'(idx_q);
    s_end    = {1'b0, baseline_len_i} + {1'b0, short_len_i};
    l_end    = {1'b0, baseline_len_i} + {1'b0, long_len_i};
    in_base  = pos < {1'b0, baseline_len_i};
    in_short = pos < s_end;
    in_long  = pos < l_end;
    last     = (pos + 1'b1) >= {1'b0, len};
    smp      = wci_pkg::SUM_W'(sample_i);
  end

  assign emit_o = !done_q && !in_base && !in_short && !in_long;

  always_comb begin
    idx_d       = idx_q;
    done_d      = done_q;
    base_sum_d  = base_sum_q;
    base_cnt_d  = base_cnt_q;
    short_sum_d = short_sum_q;
    long_sum_d  = long_sum_q;
    if (cmd_i.acc_en) begin
      if (!done_q) begin
        if (in_base) begin
          base_sum_d = base_sum_q + smp;
          base_cnt_d = base_cnt_q + 1'b1;
        end else if (in_short) begin
          short_sum_d = short_sum_q + smp;
          long_sum_d  = long_sum_q + smp;
        end else if (in_long) begin
          long_sum_d = long_sum_q + smp;
        end else begin
          done_d      = 1'b1;
          base_sum_d  = '0;
          base_cnt_d  = '0;
          short_sum_d = '0;
          long_sum_d  = '0;
        end
      end
      // record end wins over everything above
      if (last) begin
        idx_d       = '0;
        done_d      = 1'b0;
        base_sum_d  = '0;
        base_cnt_d  = '0;
        short_sum_d = '0;
        long_sum_d  = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      done_q      <= 1'b0;
      base_sum_q  <= '0;
      base_cnt_q  <= '0;
      short_sum_q <= '0;
      long_sum_q  <= '0;
    end else begin
      idx_q       <= idx_d;
      done_q      <= done_d;
      base_sum_q  <= base_sum_d;
      base_cnt_q  <= base_cnt_d;
      short_sum_q <= short_sum_d;
      long_sum_q  <= long_sum_d;
    end
  end

  assign base_sum_o   = base_sum_q;
  assign base_count_o = base_cnt_q;
  assign short_sum_o  = short_sum_q;
  assign long_sum_o   = long_sum_q;

endmodule

@@ rtl/core/wci_div.sv @@
// restoring divider for the baseline average, one quotient bit per step
// depends on wci_pkg

module wci_div (
  input  logic                       clk_i,
  input  wci_pkg::cmd_t              cmd_i,
  input  logic [wci_pkg::SUM_W-1:0]  dividend_i,
  input  logic [wci_pkg::CNT_W-1:0]  divisor_i,
  output logic [wci_pkg::SUM_W-1:0]  quotient_o,
  output logic                       den_zero_o
);

  logic [wci_pkg::SUM_W-1:0] quo_q, quo_d;
  logic [wci_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [wci_pkg::CNT_W-1:0] den_q, den_d;
  logic [wci_pkg::CNT_W:0]   trial, diff;
  logic                      fits;

  always_comb begin
    trial = {rem_q, quo_q[wci_pkg::SUM_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (cmd_i.take) begin
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cmd_i.div_step) begin
      quo_d = {quo_q[wci_pkg::SUM_W-2:0], fits};
      // remainder stays below the divisor, so the top bit drops out
      rem_d = fits ? diff[wci_pkg::CNT_W-1:0] : trial[wci_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign den_zero_o = (den_q == '0);

endmodule

@@ rtl/core/wci_post.sv @@
// baseline correction, sign flip and output register of the result word
// depends on wci_pkg

module wci_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wci_pkg::cmd_t               cmd_i,
  input  logic [wci_pkg::SUM_W-1:0]   short_sum_i,
  input  logic [wci_pkg::SUM_W-1:0]   long_sum_i,
  input  logic [wci_pkg::SUM_W-1:0]   quotient_i,
  input  logic                        den_zero_i,
  input  logic [wci_pkg::LEN_W-1:0]   short_len_i,
  input  logic [wci_pkg::LEN_W-1:0]   long_len_i,
  input  logic                        reverse_i,
  input  logic                        out_stall_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  output logic signed [wci_pkg::BASE_W-1:0] base_level_o,
  output logic signed [wci_pkg::CHG_W-1:0]  charge_short_o,
  output logic signed [wci_pkg::CHG_W-1:0]  charge_long_o
);

  logic [wci_pkg::SUM_W-1:0]    short_q, long_q;
  logic [wci_pkg::SAMPLE_W-1:0] base_q, base_d;
  logic [wci_pkg::PROD_W-1:0]   prod_s_q, prod_l_q, prod_s_d, prod_l_d;
  logic                         valid_q, valid_d;
  logic signed [wci_pkg::BASE_W-1:0] base_q_out, base_out_d;
  logic signed [wci_pkg::CHG_W-1:0]  chg_s_q, chg_l_q, chg_s_d, chg_l_d;
  logic signed [wci_pkg::DIFF_W-1:0] diff_s, diff_l;
  logic signed [wci_pkg::BASE_W-1:0] base_ext;

  // an empty baseline counts as zero
  assign base_d   = den_zero_i ? '0 : quotient_i[wci_pkg::SAMPLE_W-1:0];
  assign prod_s_d = wci_pkg::PROD_W'(short_len_i) * wci_pkg::PROD_W'(base_d);
  assign prod_l_d = wci_pkg::PROD_W'(long_len_i) * wci_pkg::PROD_W'(base_d);

  always_comb begin
    diff_s     = $signed(wci_pkg::DIFF_W'(short_q)) - $signed(wci_pkg::DIFF_W'(prod_s_q));
    diff_l     = $signed(wci_pkg::DIFF_W'(long_q)) - $signed(wci_pkg::DIFF_W'(prod_l_q));
    base_ext   = $signed(wci_pkg::BASE_W'(base_q));
    if (reverse_i) begin
      diff_s   = -diff_s;
      diff_l   = -diff_l;
      base_ext = -base_ext;
    end
    chg_s_d    = diff_s[wci_pkg::CHG_W-1:0];
    chg_l_d    = diff_l[wci_pkg::CHG_W-1:0];
    base_out_d = base_ext;
  end

  assign out_free_o = !valid_q || !out_stall_i;
  assign valid_d    = cmd_i.load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      short_q <= short_sum_i;
      long_q  <= long_sum_i;
    end
    if (cmd_i.scale) begin
      base_q   <= base_d;
      prod_s_q <= prod_s_d;
      prod_l_q <= prod_l_d;
    end
    if (cmd_i.load) begin
      base_q_out <= base_out_d;
      chg_s_q    <= chg_s_d;
      chg_l_q    <= chg_l_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign base_level_o   = base_q_out;
  assign charge_short_o = chg_s_q;
  assign charge_long_o  = chg_l_q;

endmodule

@@ rtl/core/waveform_charge_integrator_core.sv @@
// charge integrator: one sample word a cycle; a point that closes the gates stalls
// input through the 28-step divide, the scale step and the write step, where the result word is registered;
// other points are taken back to back; a waiting result word holds intake only in the write step
// reset is asynchronous active low and clears position, accumulators and output valid
// configuration resets to 1024 / 64 / 32 / 256 / not reversed
// depends on wci_pkg and the wci_* modules

`include "waveform_charge_integrator_core_defines.svh"

module waveform_charge_integrator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wci_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wci_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wci_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wci_pkg::BASE_W-1:0]  base_level_o,
  output logic signed [wci_pkg::CHG_W-1:0]   charge_short_o,
  output logic signed [wci_pkg::CHG_W-1:0]   charge_long_o
);

  logic [wci_pkg::LEN_W-1:0] wave_len_q, baseline_len_q, short_len_q, long_len_q;
  logic                      reverse_q;

  wci_pkg::cmd_t             cmd;
  wci_pkg::sts_t             sts;
  logic                      emit, out_free, den_zero;
  logic [wci_pkg::SUM_W-1:0] base_sum, short_sum, long_sum, quotient;
  logic [wci_pkg::CNT_W-1:0] base_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_len_q     <= wci_pkg::LEN_W'(1024);
      baseline_len_q <= wci_pkg::LEN_W'(64);
      short_len_q    <= wci_pkg::LEN_W'(32);
      long_len_q     <= wci_pkg::LEN_W'(256);
      reverse_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wci_pkg::CFG_WAVE_LEN:     wave_len_q     <= cfg_data_i;
        wci_pkg::CFG_BASELINE_LEN: baseline_len_q <= cfg_data_i;
        wci_pkg::CFG_SHORT_LEN:    short_len_q    <= cfg_data_i;
        wci_pkg::CFG_LONG_LEN:     long_len_q     <= cfg_data_i;
        wci_pkg::CFG_REVERSE:      reverse_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign sts.in_valid = in_valid_i;
  assign sts.emit     = emit;
  assign sts.out_free = out_free;

  wci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  wci_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sample_i       (sample_i),
    .wave_len_i     (wave_len_q),
    .baseline_len_i (baseline_len_q),
    .short_len_i    (short_len_q),
    .long_len_i     (long_len_q),
    .emit_o         (emit),
    .base_sum_o     (base_sum),
    .base_count_o   (base_count),
    .short_sum_o    (short_sum),
    .long_sum_o     (long_sum)
  );

  wci_div u_div (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dividend_i (base_sum),
    .divisor_i  (base_count),
    .quotient_o (quotient),
    .den_zero_o (den_zero)
  );

  wci_post u_post (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .short_sum_i    (short_sum),
    .long_sum_i     (long_sum),
    .quotient_i     (quotient),
    .den_zero_i     (den_zero),
    .short_len_i    (short_len_q),
    .long_len_i     (long_len_q),
    .reverse_i      (reverse_q),
    .out_stall_i    (out_stall_i),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .base_level_o   (base_level_o),
    .charge_short_o (charge_short_o),
    .charge_long_o  (charge_long_o)
  );

  `WCI_ASSERT(a_take_blocks_intake, (in_valid_i && !in_stall_o && emit) |=> in_stall_o,
      "intake not held while the baseline is divided")
  `WCI_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.load),
      "result word appeared without a write")
  `WCI_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o,
      "result word valid during reset")

endmodule
